// ----- rtl/string_literal_unescaper_assert.svh -----
// Assertion macros for the unescaper RTL
`ifndef STRING_LITERAL_UNESCAPER_ASSERT_SVH
`define STRING_LITERAL_UNESCAPER_ASSERT_SVH
`ifndef SYNTHESIS
`define SLU_ASSERT_IMPL(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error("slu assertion failed");
`define SLU_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error("slu assertion failed");
`else
`define SLU_ASSERT_IMPL(lbl, ck, rn, ante, cons)
`define SLU_ASSERT_NEXT(lbl, ck, rn, ante, cons)
`endif
`endif

// ----- rtl/slu_pkg.sv -----
package slu_pkg;

	typedef enum logic [1:0] {
		PH_TEXT = 2'd0,
		PH_ESC  = 2'd1,
		PH_HEX  = 2'd2
	} slu_phase_t;

	typedef struct packed {
		logic [7:0] data;
		logic       byte_valid;
		logic       run_last;
		logic       string_done;
	} slu_ent_t;

	typedef struct packed {
		logic [1:0]          count;
		slu_ent_t [2:0]      ent;
	} slu_res_t;

	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_U      = 8'h75;
	localparam logic [7:0] CH_N      = 8'h6E;
	localparam logic [7:0] CH_T      = 8'h74;
	localparam logic [7:0] CH_R      = 8'h72;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_CR     = 8'h0D;

	localparam logic [15:0] CP_1B_MAX = 16'h007F;
	localparam logic [15:0] CP_2B_MAX = 16'h07FF;
	localparam logic [7:0]  UTF8_LEAD2 = 8'hC0;
	localparam logic [7:0]  UTF8_LEAD3 = 8'hE0;
	localparam logic [7:0]  UTF8_CONT  = 8'h80;

	// {ok, value}
	function automatic logic [4:0] hex_value(input logic [7:0] c);
		logic [4:0] r;
		r = 5'd0;
		if (c >= 8'h30 && c <= 8'h39)
			r = {1'b1, c[3:0]};
		else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46))
			r = {1'b1, 4'(c[3:0] + 4'd9)};
		return r;
	endfunction

endpackage

// ----- rtl/string_literal_unescaper.sv -----
// Each accepted item passes an input register, then a result register, before its first result appears.
// Throughput: one item per cycle while each item yields at most one result and m_tready is high.
// An item that yields k results holds the result register until all k have been taken.
// Reset (arst_n low, asynchronous) empties both registers and returns the decoder
// to plain text awaiting an opening byte.
module string_literal_unescaper (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // in_byte
	input  logic       s_tlast,   // literal_end
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,   // out_byte
	output logic [1:0] m_tuser,   // byte_valid, run_last
	output logic       m_tlast    // string_done
);
	import slu_pkg::*;

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       end_s1;
	logic       free;
	logic       adv;
	slu_res_t   res;

	assign adv = valid_s1 && free;
	assign s_tready = !valid_s1 || free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1 <= s_tdata;
			end_s1 <= s_tlast;
		end
	end

	slu_decode u_decode (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (adv),
		.byte_s1 (byte_s1),
		.end_s1  (end_s1),
		.res     (res)
	);

	slu_outbuf u_outbuf (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (adv),
		.res      (res),
		.free     (free),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

endmodule

// ----- rtl/slu_decode.sv -----
module slu_decode (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                advance,
	input  logic [7:0]          byte_s1,
	input  logic                end_s1,
	output slu_pkg::slu_res_t   res
);
	import slu_pkg::*;

	slu_phase_t  phase_q, phase_n;
	logic        open_q, open_n;
	logic [1:0]  ndig_q, ndig_n;
	logic [11:0] acc_q, acc_n;

	logic [7:0]  d [3];
	logic        v0;
	logic [1:0]  cnt;
	logic [4:0]  hx;
	logic [15:0] cp;

	always_comb begin
		d[0] = 8'd0;
		d[1] = 8'd0;
		d[2] = 8'd0;
		v0 = 1'b1;
		cnt = 2'd0;
		phase_n = phase_q;
		open_n = open_q;
		ndig_n = ndig_q;
		acc_n = acc_q;
		hx = hex_value(byte_s1);
		cp = {acc_q, hx[3:0]};
		if (!open_q) begin
			if (end_s1) begin
				d[0] = byte_s1;
				cnt = 2'd1;
			end else begin
				open_n = 1'b1;
			end
		end else if (end_s1) begin
			cnt = 2'd1;
			unique case (phase_q)
				PH_ESC: d[0] = CH_BSLASH;
				PH_HEX: d[0] = CH_U;
				default: v0 = 1'b0;
			endcase
		end else begin
			unique case (phase_q)
				PH_ESC: begin
					phase_n = PH_TEXT;
					cnt = 2'd1;
					case (byte_s1)
						CH_N: d[0] = CH_LF;
						CH_T: d[0] = CH_TAB;
						CH_R: d[0] = CH_CR;
						CH_U: begin
							cnt = 2'd0;
							phase_n = PH_HEX;
							ndig_n = 2'd0;
							acc_n = 12'd0;
						end
						default: d[0] = byte_s1;
					endcase
				end
				PH_HEX: begin
					if (!hx[4]) begin
						d[0] = CH_U;
						cnt = 2'd1;
						phase_n = PH_TEXT;
						ndig_n = 2'd0;
						acc_n = 12'd0;
					end else if (ndig_q == 2'd3) begin
						phase_n = PH_TEXT;
						ndig_n = 2'd0;
						acc_n = 12'd0;
						if (cp <= CP_1B_MAX) begin
							d[0] = cp[7:0];
							cnt = 2'd1;
						end else if (cp <= CP_2B_MAX) begin
							d[0] = UTF8_LEAD2 | {3'b000, cp[10:6]};
							d[1] = UTF8_CONT | {2'b00, cp[5:0]};
							cnt = 2'd2;
						end else begin
							d[0] = UTF8_LEAD3 | {4'b0000, cp[15:12]};
							d[1] = UTF8_CONT | {2'b00, cp[11:6]};
							d[2] = UTF8_CONT | {2'b00, cp[5:0]};
							cnt = 2'd3;
						end
					end else begin
						acc_n = {acc_q[7:0], hx[3:0]};
						ndig_n = ndig_q + 2'd1;
					end
				end
				default: begin
					if (byte_s1 == CH_BSLASH)
						phase_n = PH_ESC;
					else begin
						d[0] = byte_s1;
						cnt = 2'd1;
					end
				end
			endcase
		end
		if (end_s1) begin
			phase_n = PH_TEXT;
			open_n = 1'b0;
			ndig_n = 2'd0;
			acc_n = 12'd0;
		end
	end

	always_comb begin
		res.count = cnt;
		for (int i = 0; i < 3; i++) begin
			res.ent[i].data = d[i];
			res.ent[i].byte_valid = (i == 0) ? v0 : 1'b1;
			res.ent[i].run_last = (cnt == 2'(i + 1));
			res.ent[i].string_done = end_s1 && (cnt == 2'(i + 1));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_TEXT;
			open_q <= 1'b0;
			ndig_q <= 2'd0;
			acc_q <= 12'd0;
		end else if (advance) begin
			phase_q <= phase_n;
			open_q <= open_n;
			ndig_q <= ndig_n;
			acc_q <= acc_n;
		end
	end

endmodule

// ----- rtl/slu_outbuf.sv -----
`include "string_literal_unescaper_assert.svh"

module slu_outbuf (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              load,
	input  slu_pkg::slu_res_t res,
	output logic              free,
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [7:0]        m_tdata,   // out_byte
	output logic [1:0]        m_tuser,   // byte_valid, run_last
	output logic              m_tlast    // string_done
);
	import slu_pkg::*;

	slu_ent_t   ent_q [3];
	logic [1:0] rem_q;
	logic       pop;

	assign pop = (rem_q != 2'd0) && m_tready;
	assign free = (rem_q == 2'd0) || ((rem_q == 2'd1) && m_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q <= 2'd0;
		end else if (load) begin
			rem_q <= res.count;
		end else if (pop) begin
			rem_q <= rem_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load && res.count != 2'd0) begin
			ent_q[0] <= res.ent[0];
			ent_q[1] <= res.ent[1];
			ent_q[2] <= res.ent[2];
		end else if (pop) begin
			ent_q[0] <= ent_q[1];
			ent_q[1] <= ent_q[2];
		end
	end

	assign m_tvalid = (rem_q != 2'd0);
	assign m_tdata = ent_q[0].data;
	assign m_tuser = {ent_q[0].run_last, ent_q[0].byte_valid};
	assign m_tlast = ent_q[0].string_done;

	`SLU_ASSERT_IMPL(a_done_is_run_end, clk, arst_n, m_tvalid && m_tlast, m_tuser[1])
	`SLU_ASSERT_IMPL(a_marker_zero, clk, arst_n, m_tvalid && !m_tuser[0],
		(m_tdata == 8'd0) && m_tuser[1] && m_tlast)
	`SLU_ASSERT_NEXT(a_drain_last, clk, arst_n, pop && (rem_q == 2'd1) && !load,
		rem_q == 2'd0)
	`SLU_ASSERT_IMPL(a_run_end_last_slot, clk, arst_n, m_tvalid && m_tuser[1],
		rem_q == 2'd1)

endmodule

// ----- test/tb_string_literal_unescaper.sv -----
module tb_string_literal_unescaper;
	timeunit 1ns;
	timeprecision 1ps;

	import slu_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int RANDOM_ITEMS = 240;

	typedef struct {
		logic [7:0] b;
		logic       last;
		bit         drain;
		int         gap;
	} lit_item_t;

	typedef struct {
		logic [7:0] data;
		logic       valid;
		logic       run_last;
		logic       done;
	} dec_byte_t;

	logic       clk;
	logic       arst_n = 1'b0;
	logic       s_tvalid = 1'b0;
	logic       s_tready;
	logic [7:0] s_tdata = 8'h00;
	logic       s_tlast = 1'b0;
	logic       m_tvalid;
	logic       m_tready = 1'b0;
	logic [7:0] m_tdata;
	logic [1:0] m_tuser;
	logic       m_tlast;

	string_literal_unescaper uut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tlast(s_tlast),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.m_tlast(m_tlast)
	);

	lit_item_t  lit_bytes[$];
	dec_byte_t  decoded_due[$];

	slu_phase_t dec_phase = PH_TEXT;
	bit         dec_open = 1'b0;
	logic [1:0] dec_ndig = 2'd0;
	logic [11:0] dec_acc = 12'd0;

	int errors = 0;
	int cycles = 0;
	int items_sent = 0;
	int bytes_checked = 0;
	int literals_done = 0;
	int uni_done = 0;
	int n_gen = 0;
	int quiet_left = 0;

	int        send_wait = 0;
	logic      tx_valid;
	lit_item_t tx_item;

	int   hold_cnt = 0;
	bit   hold_done = 1'b0;
	int   rx_left = 0;
	bit   rx_calm = 1'b0;
	int   stall_left = 0;
	int   rx_roll;
	logic rx_ready;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic int nibble_of(input logic [7:0] c);
		if (c >= "0" && c <= "9")
			return c - "0";
		if (c >= "a" && c <= "f")
			return c - "a" + 10;
		if (c >= "A" && c <= "F")
			return c - "A" + 10;
		return -1;
	endfunction

	function automatic logic [7:0] hex_char(input logic [3:0] v, input bit upper);
		if (v < 10)
			return 8'h30 + {4'd0, v};
		return 8'((upper ? 8'h41 : 8'h61) + {4'd0, v} - 8'd10);
	endfunction

	function automatic dec_byte_t mk(input logic [7:0] d, input logic v);
		dec_byte_t e;
		e.data = d;
		e.valid = v;
		e.run_last = 1'b0;
		e.done = 1'b0;
		return e;
	endfunction

	task automatic decode_byte(input logic [7:0] b, input logic last);
		dec_byte_t res[$];
		int hv;
		logic [15:0] cp;
		if (!dec_open) begin
			if (last)
				res.push_back(mk(b, 1'b1));
			else
				dec_open = 1'b1;
		end else if (last) begin
			if (dec_phase == PH_ESC)
				res.push_back(mk(CH_BSLASH, 1'b1));
			else if (dec_phase == PH_HEX)
				res.push_back(mk(CH_U, 1'b1));
			else
				res.push_back(mk(8'h00, 1'b0));
		end else begin
			case (dec_phase)
				PH_ESC: begin
					dec_phase = PH_TEXT;
					case (b)
						CH_N: res.push_back(mk(CH_LF, 1'b1));
						CH_T: res.push_back(mk(CH_TAB, 1'b1));
						CH_R: res.push_back(mk(CH_CR, 1'b1));
						CH_U: begin
							dec_phase = PH_HEX;
							dec_ndig = 2'd0;
							dec_acc = 12'd0;
						end
						default: res.push_back(mk(b, 1'b1));
					endcase
				end
				PH_HEX: begin
					hv = nibble_of(b);
					if (hv < 0) begin
						res.push_back(mk(CH_U, 1'b1));
						dec_phase = PH_TEXT;
						dec_ndig = 2'd0;
						dec_acc = 12'd0;
					end else if (dec_ndig == 2'd3) begin
						cp = {dec_acc, hv[3:0]};
						if (cp <= CP_1B_MAX) begin
							res.push_back(mk(cp[7:0], 1'b1));
						end else if (cp <= CP_2B_MAX) begin
							res.push_back(mk(UTF8_LEAD2 | {3'b000, cp[10:6]}, 1'b1));
							res.push_back(mk(UTF8_CONT | {2'b00, cp[5:0]}, 1'b1));
						end else begin
							res.push_back(mk(UTF8_LEAD3 | {4'b0000, cp[15:12]}, 1'b1));
							res.push_back(mk(UTF8_CONT | {2'b00, cp[11:6]}, 1'b1));
							res.push_back(mk(UTF8_CONT | {2'b00, cp[5:0]}, 1'b1));
						end
						uni_done++;
						dec_phase = PH_TEXT;
						dec_ndig = 2'd0;
						dec_acc = 12'd0;
					end else begin
						dec_acc = {dec_acc[7:0], hv[3:0]};
						dec_ndig = dec_ndig + 2'd1;
					end
				end
				default: begin
					if (b == CH_BSLASH)
						dec_phase = PH_ESC;
					else
						res.push_back(mk(b, 1'b1));
				end
			endcase
		end
		if (last) begin
			dec_phase = PH_TEXT;
			dec_open = 1'b0;
			dec_ndig = 2'd0;
			dec_acc = 12'd0;
			literals_done++;
		end
		if (res.size() > 0) begin
			res[res.size() - 1].run_last = 1'b1;
			if (last)
				res[res.size() - 1].done = 1'b1;
		end
		foreach (res[i])
			decoded_due.push_back(res[i]);
	endtask

	task automatic push_item(input logic [7:0] b, input logic last, input bit drain = 1'b0);
		lit_item_t it;
		int r;
		it.b = b;
		it.last = last;
		it.drain = drain;
		if (quiet_left > 0) begin
			quiet_left--;
			it.gap = 0;
		end else begin
			r = $urandom_range(0, 99);
			if (r < 4)
				quiet_left = $urandom_range(20, 50);
			if (r < 55)
				it.gap = 0;
			else if (r < 92)
				it.gap = $urandom_range(1, 3);
			else
				it.gap = $urandom_range(6, 25);
		end
		lit_bytes.push_back(it);
		n_gen++;
	endtask

	task automatic push_hex(input logic [3:0] v);
		push_item(hex_char(v, 1'($urandom_range(0, 1))), 1'b0);
	endtask

	task automatic push_bad_hex();
		logic [7:0] c;
		c = 8'($urandom_range(0, 255));
		while (nibble_of(c) >= 0)
			c = 8'($urandom_range(0, 255));
		push_item(c, 1'b0);
	endtask

	task automatic gen_literal(input bit drain);
		int ntok;
		int kind;
		int nd;
		logic [15:0] cp;
		logic [7:0] c;
		if ($urandom_range(0, 19) == 0) begin
			push_item(8'($urandom_range(0, 255)), 1'b1, drain);
			return;
		end
		push_item(8'($urandom_range(0, 255)), 1'b0, drain);
		ntok = $urandom_range(0, 6);
		repeat (ntok) begin
			kind = $urandom_range(0, 99);
			if (kind < 35) begin
				c = 8'($urandom_range(0, 255));
				if (c == CH_BSLASH)
					c = 8'h41;
				push_item(c, 1'b0);
			end else if (kind < 55) begin
				push_item(CH_BSLASH, 1'b0);
				case ($urandom_range(0, 7))
					0: c = CH_N;
					1: c = CH_T;
					2: c = CH_R;
					3: c = CH_BSLASH;
					4: c = 8'h22;
					5: c = 8'h27;
					6: c = 8'h24;
					default: begin
						c = 8'($urandom_range(0, 255));
						if (c == CH_U)
							c = 8'h00;
					end
				endcase
				push_item(c, 1'b0);
			end else if (kind < 85) begin
				case ($urandom_range(0, 2))
					0: cp = 16'($urandom_range(0, 16'h007F));
					1: cp = 16'($urandom_range(16'h0080, 16'h07FF));
					default: cp = 16'($urandom_range(16'h0800, 16'hFFFF));
				endcase
				push_item(CH_BSLASH, 1'b0);
				push_item(CH_U, 1'b0);
				push_hex(cp[15:12]);
				push_hex(cp[11:8]);
				push_hex(cp[7:4]);
				push_hex(cp[3:0]);
			end else begin
				push_item(CH_BSLASH, 1'b0);
				push_item(CH_U, 1'b0);
				nd = $urandom_range(0, 3);
				repeat (nd)
					push_hex(4'($urandom_range(0, 15)));
				push_bad_hex();
			end
		end
		case ($urandom_range(0, 9))
			0: push_item(CH_BSLASH, 1'b0);
			1: begin
				push_item(CH_BSLASH, 1'b0);
				push_item(CH_U, 1'b0);
				nd = $urandom_range(0, 3);
				repeat (nd)
					push_hex(4'($urandom_range(0, 15)));
			end
			default: ;
		endcase
		push_item(8'($urandom_range(0, 255)), 1'b1);
	endtask

	function automatic void cmp_field(input string name, input logic [7:0] want,
			input logic [7:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
			errors++;
		end
	endfunction

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles", cycles);
			$display("Some tests failed");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			tx_valid = s_tvalid;
			if (s_tvalid && s_tready) begin
				decode_byte(s_tdata, s_tlast);
				items_sent++;
				tx_valid = 1'b0;
			end
			if (!tx_valid && lit_bytes.size() > 0
					&& !(lit_bytes[0].drain && decoded_due.size() > 0)) begin
				if (send_wait < lit_bytes[0].gap) begin
					send_wait++;
				end else begin
					tx_item = lit_bytes.pop_front();
					s_tdata <= tx_item.b;
					s_tlast <= tx_item.last;
					tx_valid = 1'b1;
					send_wait = 0;
				end
			end
			s_tvalid <= tx_valid;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				if (decoded_due.size() == 0) begin
					$display("%0t: unexpected output item, expected none actual data %h user %b last %b",
						$time, m_tdata, m_tuser, m_tlast);
					errors++;
				end else begin
					dec_byte_t e;
					e = decoded_due.pop_front();
					cmp_field("out_byte", e.data, m_tdata);
					cmp_field("byte_valid", {7'd0, e.valid}, {7'd0, m_tuser[0]});
					cmp_field("run_last", {7'd0, e.run_last}, {7'd0, m_tuser[1]});
					cmp_field("string_done", {7'd0, e.done}, {7'd0, m_tlast});
					bytes_checked++;
				end
			end
			if (hold_cnt > 0) begin
				hold_cnt--;
				rx_ready = 1'b0;
			end else if (!hold_done && items_sent >= 150) begin
				hold_done = 1'b1;
				hold_cnt = 250;
				rx_ready = 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				rx_ready = 1'b0;
			end else begin
				if (rx_left == 0) begin
					rx_calm = ($urandom_range(0, 2) == 0);
					rx_left = $urandom_range(20, 80);
				end
				rx_left--;
				rx_roll = $urandom_range(0, 99);
				if (!rx_calm && rx_roll < 25) begin
					stall_left = (rx_roll < 3) ? $urandom_range(10, 30) : $urandom_range(0, 2);
					rx_ready = 1'b0;
				end else begin
					rx_ready = 1'b1;
				end
			end
			m_tready <= rx_ready;
		end
	end

	initial begin
		int lit_idx;
		push_item(8'hFF, 1'b1);
		push_item(8'h00, 1'b0);
		push_item(8'h22, 1'b1);
		push_item(8'h22, 1'b0);
		push_item(CH_BSLASH, 1'b0);
		push_item(CH_N, 1'b0);
		push_item(CH_BSLASH, 1'b0);
		push_item(CH_T, 1'b0);
		push_item(CH_BSLASH, 1'b0);
		push_item(CH_R, 1'b0);
		push_item(CH_BSLASH, 1'b0);
		push_item(CH_U, 1'b0);
		push_item("F", 1'b0);
		push_item("f", 1'b0);
		push_item("F", 1'b0);
		push_item("f", 1'b0);
		push_item(8'h22, 1'b1);
		push_item(8'h00, 1'b0);
		push_item(CH_BSLASH, 1'b0);
		push_item(8'hFF, 1'b1);
		push_item(8'h27, 1'b0);
		push_item(CH_BSLASH, 1'b0);
		push_item(CH_U, 1'b0);
		push_item("7", 1'b0);
		push_item("G", 1'b0);
		push_item(CH_BSLASH, 1'b0);
		push_item(CH_U, 1'b0);
		push_item("0", 1'b0);
		push_item(8'h27, 1'b1);
		lit_idx = 0;
		while (n_gen < 29 + RANDOM_ITEMS) begin
			gen_literal(lit_idx == 0 || lit_idx == 20);
			lit_idx++;
		end

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		while (lit_bytes.size() > 0 || s_tvalid)
			@(posedge clk);
		while (decoded_due.size() > 0)
			@(posedge clk);
		repeat (20) @(posedge clk);

		$display("Sent %0d items in %0d literals, checked %0d output items", items_sent,
			literals_done, bytes_checked);
		$display("including %0d complete \\u escapes", uni_done);
		if (errors == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
